// File: hw/rtl/fat_chain_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_MACROS_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// Condition must hold at every clock edge out of reset.
`define FCBA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("allocator invariant violated");
// Antecedent implies consequent in the same cycle.
`define FCBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator implication violated");
// Antecedent implies consequent in the next cycle.
`define FCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator sequence violated");
`else
`define FCBA_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define FCBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/fcba_pkg.sv
// Types, codes and defaults shared by the allocator modules.
package fcba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF   = 256;
  localparam int unsigned ROOT_ENTRIES_DEF = 16;
  localparam int unsigned TABLE_BLOCKS_DEF = 4;

  localparam int unsigned NAME_W = 48;
  localparam int unsigned BLKN_W = 8;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 3;

  localparam logic [NAME_W-1:0] EMPTY_NAME = 48'h585858585858;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 3'd0,
    OP_REMOVE = 3'd1,
    OP_APPEND = 3'd2,
    OP_DELETE = 3'd3,
    OP_NEXT   = 3'd4,
    OP_CHECK  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_NOFILE   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTIN    = 3'd4,
    ST_NOTEMPTY = 3'd5
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [NAME_W-1:0] name_key;
    logic [BLKN_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLKN_W-1:0] result_block;
  } rsp_t;

  // Directory port controls.
  typedef struct packed {
    logic rd;
    logic wr_name;
    logic wr_first;
    logic set_occ;
    logic clr_occ;
  } dir_ctl_t;

endpackage

// File: hw/rtl/fcba_dir.sv
// Root directory: slot names, first-block numbers and occupied bits.
module fcba_dir #(
  parameter int unsigned ROOT_ENTRIES = fcba_pkg::ROOT_ENTRIES_DEF,
  parameter int unsigned CW           = 9,
  localparam int unsigned SW          = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcba_pkg::dir_ctl_t            ctl_i,
  input  logic [SW-1:0]                 raddr_i,
  input  logic [SW-1:0]                 waddr_i,
  input  logic [fcba_pkg::NAME_W-1:0]   wname_i,
  input  logic [CW-1:0]                 wfirst_i,
  output logic [fcba_pkg::NAME_W-1:0]   name_o,
  output logic [CW-1:0]                 first_o,
  output logic [ROOT_ENTRIES-1:0]       occ_o
);

  logic [fcba_pkg::NAME_W-1:0] name_mem [ROOT_ENTRIES];
  logic [CW-1:0]               first_mem [ROOT_ENTRIES];
  logic [ROOT_ENTRIES-1:0]     occ_q;
  logic [fcba_pkg::NAME_W-1:0] name_q;
  logic [CW-1:0]               first_q;

  // An unoccupied slot keeps whatever name it last held; its stored name is never looked at.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (ctl_i.set_occ) begin
      occ_q[waddr_i] <= 1'b1;
    end else if (ctl_i.clr_occ) begin
      occ_q[waddr_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_name) begin
      name_mem[waddr_i] <= wname_i;
    end
    if (ctl_i.rd) begin
      name_q <= name_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_first) begin
      first_mem[waddr_i] <= wfirst_i;
    end
    if (ctl_i.rd) begin
      first_q <= first_mem[raddr_i];
    end
  end

  assign name_o  = name_q;
  assign first_o = first_q;
  assign occ_o   = occ_q;

endmodule

// File: hw/rtl/fcba_fat_ram.sv
// Chain table memory: one write port, one registered read port.
module fcba_fat_ram #(
  parameter int unsigned NUM_BLOCKS = fcba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BW         = 8,
  parameter int unsigned CW         = 9
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [BW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [BW-1:0] waddr_i,
  input  logic [CW-1:0] wdata_i,
  output logic [CW-1:0] rdata_o
);

  logic [CW-1:0] mem [NUM_BLOCKS];
  logic [CW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fcba_walk.sv
// Chain walk unit: step bound counter, block-range check and target compare.
module fcba_walk #(
  parameter int unsigned NUM_BLOCKS = fcba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned CW         = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        adv_i,
  input  logic [CW-1:0]               cur_i,
  input  logic [fcba_pkg::BLKN_W-1:0] target_i,
  output logic                        ok_o,
  output logic                        hit_o
);

  localparam int unsigned STW = $clog2(NUM_BLOCKS + 1);

  logic [STW-1:0] steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else if (clr_i) begin
      steps_q <= '0;
    end else if (adv_i) begin
      steps_q <= steps_q + STW'(1);
    end
  end

  // Keep walking while under the step bound and on a real block.
  assign ok_o  = (steps_q < STW'(NUM_BLOCKS)) && (cur_i != '0) && (cur_i < CW'(NUM_BLOCKS));
  assign hit_o = (32'(cur_i) == 32'(target_i));

endmodule

// File: hw/rtl/fat_chain_block_allocator.sv
// Top level: FAT block allocator sequencer with directory and chain table.
//
// Commands enter on start when busy is low, one at a time; each returns exactly
// one result on rsp_o, marked by a one-cycle done_o pulse that cannot be held
// off. After reset the block stays busy while it writes the initial free chain
// into the chain table. A command with an unknown opcode, or with the
// empty-marker name and any opcode but append, answers without a scan; append
// first reads the free-list head, so a full table or the marker name answers
// straight after that read. Otherwise the directory is scanned one slot a
// cycle through its registered read port, ending early on a match. Delete,
// next and check then walk the chain one block a cycle through the chain
// table read port, bounded by the step counter at NUM_BLOCKS blocks; delete
// then unlinks the block and returns it to the free-list head. Append adds a
// free-head read, a walk to the tail and up to three table writes.
`include "fat_chain_block_allocator_macros.svh"

module fat_chain_block_allocator #(
  parameter int unsigned NUM_BLOCKS   = fcba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned ROOT_ENTRIES = fcba_pkg::ROOT_ENTRIES_DEF,
  parameter int unsigned TABLE_BLOCKS = fcba_pkg::TABLE_BLOCKS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  fcba_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output fcba_pkg::rsp_t rsp_o
);

  localparam int unsigned BW  = $clog2(NUM_BLOCKS);
  localparam int unsigned CW  = BW + 1;
  localparam int unsigned SW  = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
  localparam int unsigned SCW = $clog2(ROOT_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_APP_CHK,
    S_SCAN,
    S_APP_NXT,
    S_TAIL,
    S_APP_W0,
    S_APP_W1,
    S_FIND,
    S_NXT_R,
    S_DEL_R,
    S_DEL_H,
    S_DEL_T
  } state_e;

  function automatic logic is_blk(input logic [CW-1:0] v);
    return (v != '0) && (v < CW'(NUM_BLOCKS));
  endfunction

  // Initial chain table contents: free list through the data blocks.
  function automatic logic [CW-1:0] init_val(input logic [BW-1:0] b);
    int unsigned fd;
    int unsigned bi;
    logic [CW-1:0] v;
    fd = 2 + TABLE_BLOCKS;
    bi = 32'(b);
    if (bi == 0) begin
      v = (fd < NUM_BLOCKS) ? CW'(fd) : '0;
    end else if (bi < fd) begin
      v = CW'(2 * NUM_BLOCKS - 1);
    end else begin
      v = (bi + 1 < NUM_BLOCKS) ? CW'(bi + 1) : '0;
    end
    return v;
  endfunction

  state_e                        state_q, state_d;
  logic [fcba_pkg::OP_W-1:0]     op_q, op_d;
  logic [fcba_pkg::NAME_W-1:0]   key_q, key_d;
  logic [fcba_pkg::BLKN_W-1:0]   bn_q, bn_d;
  logic [BW-1:0]                 alloc_q, alloc_d;
  logic [CW-1:0]                 nfree_q, nfree_d;
  logic [SW-1:0]                 slot_q, slot_d;
  logic [CW-1:0]                 first_q, first_d;
  logic [CW-1:0]                 b_q, b_d;
  logic [BW-1:0]                 prev_q, prev_d;
  logic                          use_rd_q, use_rd_d;
  logic [SCW-1:0]                sc_addr_q, sc_addr_d;
  logic                          cmp_vld_q, cmp_vld_d;
  logic [SW-1:0]                 cmp_idx_q, cmp_idx_d;
  logic                          free_found_q, free_found_d;
  logic [SW-1:0]                 free_idx_q, free_idx_d;
  logic [BW-1:0]                 init_q, init_d;
  logic                          done_q, done_d;
  fcba_pkg::rsp_t                rsp_q, rsp_d;

  logic                          fat_re, fat_we;
  logic [BW-1:0]                 fat_raddr, fat_waddr;
  logic [CW-1:0]                 fat_wdata, fat_rdata;

  fcba_pkg::dir_ctl_t            dir_ctl;
  logic [SW-1:0]                 dir_raddr, dir_waddr;
  logic [CW-1:0]                 dir_wfirst;
  logic [fcba_pkg::NAME_W-1:0]   dir_name;
  logic [CW-1:0]                 dir_first;
  logic [ROOT_ENTRIES-1:0]       dir_occ;

  logic                          walk_clr, walk_adv, walk_ok, walk_hit;
  logic [CW-1:0]                 walk_cur;

  fcba_dir #(
    .ROOT_ENTRIES (ROOT_ENTRIES),
    .CW           (CW)
  ) u_dir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dir_ctl),
    .raddr_i  (dir_raddr),
    .waddr_i  (dir_waddr),
    .wname_i  (key_q),
    .wfirst_i (dir_wfirst),
    .name_o   (dir_name),
    .first_o  (dir_first),
    .occ_o    (dir_occ)
  );

  fcba_fat_ram #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BW         (BW),
    .CW         (CW)
  ) u_fat (
    .clk_i   (clk_i),
    .re_i    (fat_re),
    .raddr_i (fat_raddr),
    .we_i    (fat_we),
    .waddr_i (fat_waddr),
    .wdata_i (fat_wdata),
    .rdata_o (fat_rdata)
  );

  fcba_walk #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .CW         (CW)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (walk_clr),
    .adv_i    (walk_adv),
    .cur_i    (walk_cur),
    .target_i (bn_q),
    .ok_o     (walk_ok),
    .hit_o    (walk_hit)
  );

  // The first block of a search comes from the directory; later ones from the table.
  assign walk_cur = (state_q == S_FIND && !use_rd_q) ? b_q : fat_rdata;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    bn_d         = bn_q;
    alloc_d      = alloc_q;
    nfree_d      = nfree_q;
    slot_d       = slot_q;
    first_d      = first_q;
    b_d          = b_q;
    prev_d       = prev_q;
    use_rd_d     = use_rd_q;
    sc_addr_d    = sc_addr_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    init_d       = init_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    fat_re       = 1'b0;
    fat_raddr    = '0;
    fat_we       = 1'b0;
    fat_waddr    = '0;
    fat_wdata    = '0;
    dir_ctl      = '0;
    dir_raddr    = '0;
    dir_waddr    = '0;
    dir_wfirst   = '0;
    walk_clr     = 1'b0;
    walk_adv     = 1'b0;

    case (state_q)
      S_INIT: begin
        fat_we    = 1'b1;
        fat_waddr = init_q;
        fat_wdata = init_val(init_q);
        if (init_q == BW'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end else begin
          init_d = init_q + BW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          op_d         = req_i.opcode;
          key_d        = req_i.name_key;
          bn_d         = req_i.block_number;
          sc_addr_d    = '0;
          cmp_vld_d    = 1'b0;
          free_found_d = 1'b0;
          rsp_d.result_block = '0;
          if (req_i.opcode == fcba_pkg::OP_APPEND) begin
            fat_re    = 1'b1;
            fat_raddr = '0;
            state_d   = S_APP_CHK;
          end else if (!(req_i.opcode inside {[fcba_pkg::OP_CREATE:fcba_pkg::OP_CHECK]})) begin
            done_d       = 1'b1;
            rsp_d.status = fcba_pkg::ST_NOFILE;
          end else if (req_i.name_key == fcba_pkg::EMPTY_NAME) begin
            done_d       = 1'b1;
            rsp_d.status = (req_i.opcode == fcba_pkg::OP_CREATE) ?
                           fcba_pkg::ST_EXISTS : fcba_pkg::ST_NOFILE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_APP_CHK: begin
        alloc_d = fat_rdata[BW-1:0];
        if (!is_blk(fat_rdata)) begin
          done_d       = 1'b1;
          rsp_d.status = fcba_pkg::ST_FULL;
          state_d      = S_IDLE;
        end else if (key_q == fcba_pkg::EMPTY_NAME) begin
          done_d       = 1'b1;
          rsp_d.status = fcba_pkg::ST_NOFILE;
          state_d      = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one slot read a cycle; compare the slot read the cycle before.
        if (sc_addr_q < SCW'(ROOT_ENTRIES)) begin
          dir_ctl.rd = 1'b1;
          dir_raddr  = sc_addr_q[SW-1:0];
          sc_addr_d  = sc_addr_q + SCW'(1);
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = sc_addr_q[SW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q && dir_occ[cmp_idx_q] && dir_name == key_q) begin
          slot_d  = cmp_idx_q;
          first_d = dir_first;
          case (op_q)
            fcba_pkg::OP_CREATE: begin
              done_d       = 1'b1;
              rsp_d.status = fcba_pkg::ST_EXISTS;
              state_d      = S_IDLE;
            end
            fcba_pkg::OP_REMOVE: begin
              done_d  = 1'b1;
              state_d = S_IDLE;
              if (dir_first != '0) begin
                rsp_d.status = fcba_pkg::ST_NOTEMPTY;
              end else begin
                dir_ctl.clr_occ = 1'b1;
                dir_waddr       = cmp_idx_q;
                rsp_d.status    = fcba_pkg::ST_OK;
              end
            end
            fcba_pkg::OP_APPEND: begin
              fat_re    = 1'b1;
              fat_raddr = alloc_q;
              state_d   = S_APP_NXT;
            end
            default: begin
              b_d      = dir_first;
              use_rd_d = 1'b0;
              prev_d   = '0;
              walk_clr = 1'b1;
              state_d  = S_FIND;
            end
          endcase
        end else if (cmp_vld_q) begin
          if (!dir_occ[cmp_idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
        end else if (sc_addr_q == SCW'(ROOT_ENTRIES)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (op_q == fcba_pkg::OP_CREATE) begin
            if (free_found_q) begin
              dir_ctl.wr_name  = 1'b1;
              dir_ctl.wr_first = 1'b1;
              dir_ctl.set_occ  = 1'b1;
              dir_waddr        = free_idx_q;
              dir_wfirst       = '0;
              rsp_d.status     = fcba_pkg::ST_OK;
            end else begin
              rsp_d.status = fcba_pkg::ST_FULL;
            end
          end else begin
            rsp_d.status = fcba_pkg::ST_NOFILE;
          end
        end
      end

      S_APP_NXT: begin
        nfree_d = fat_rdata;
        if (is_blk(first_q)) begin
          fat_re    = 1'b1;
          fat_raddr = first_q[BW-1:0];
          b_d       = first_q;
          walk_clr  = 1'b1;
          state_d   = S_TAIL;
        end else begin
          dir_ctl.wr_first = 1'b1;
          dir_waddr        = slot_q;
          dir_wfirst       = CW'(alloc_q);
          state_d          = S_APP_W0;
        end
      end

      S_TAIL: begin
        if (walk_ok) begin
          b_d       = fat_rdata;
          walk_adv  = 1'b1;
          fat_re    = 1'b1;
          fat_raddr = fat_rdata[BW-1:0];
        end else begin
          // Link the new block behind the tail.
          fat_we    = 1'b1;
          fat_waddr = b_q[BW-1:0];
          fat_wdata = CW'(alloc_q);
          state_d   = S_APP_W0;
        end
      end

      S_APP_W0: begin
        fat_we    = 1'b1;
        fat_waddr = '0;
        fat_wdata = is_blk(nfree_q) ? nfree_q : '0;
        state_d   = S_APP_W1;
      end

      S_APP_W1: begin
        fat_we             = 1'b1;
        fat_waddr          = alloc_q;
        fat_wdata          = '0;
        done_d             = 1'b1;
        rsp_d.status       = fcba_pkg::ST_OK;
        rsp_d.result_block = fcba_pkg::BLKN_W'(alloc_q);
        state_d            = S_IDLE;
      end

      S_FIND: begin
        if (!walk_ok) begin
          done_d       = 1'b1;
          rsp_d.status = fcba_pkg::ST_NOTIN;
          state_d      = S_IDLE;
        end else if (walk_hit) begin
          // Fetch the successor of the found block.
          fat_re    = 1'b1;
          fat_raddr = walk_cur[BW-1:0];
          case (op_q)
            fcba_pkg::OP_NEXT:   state_d = S_NXT_R;
            fcba_pkg::OP_DELETE: state_d = S_DEL_R;
            default: begin
              done_d       = 1'b1;
              rsp_d.status = fcba_pkg::ST_OK;
              state_d      = S_IDLE;
            end
          endcase
        end else begin
          prev_d    = walk_cur[BW-1:0];
          use_rd_d  = 1'b1;
          walk_adv  = 1'b1;
          fat_re    = 1'b1;
          fat_raddr = walk_cur[BW-1:0];
        end
      end

      S_NXT_R: begin
        done_d             = 1'b1;
        rsp_d.status       = fcba_pkg::ST_OK;
        rsp_d.result_block = is_blk(fat_rdata) ? fcba_pkg::BLKN_W'(fat_rdata) : '0;
        state_d            = S_IDLE;
      end

      S_DEL_R: begin
        // Unlink: bypass the block in its chain, and fetch the free head.
        if (prev_q == '0) begin
          dir_ctl.wr_first = 1'b1;
          dir_waddr        = slot_q;
          dir_wfirst       = fat_rdata;
        end else begin
          fat_we    = 1'b1;
          fat_waddr = prev_q;
          fat_wdata = fat_rdata;
        end
        fat_re    = 1'b1;
        fat_raddr = '0;
        state_d   = S_DEL_H;
      end

      S_DEL_H: begin
        fat_we    = 1'b1;
        fat_waddr = BW'(bn_q);
        fat_wdata = fat_rdata;
        state_d   = S_DEL_T;
      end

      S_DEL_T: begin
        fat_we       = 1'b1;
        fat_waddr    = '0;
        fat_wdata    = CW'(bn_q);
        done_d       = 1'b1;
        rsp_d.status = fcba_pkg::ST_OK;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      init_q       <= '0;
      done_q       <= 1'b0;
      sc_addr_q    <= '0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
      use_rd_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      done_q       <= done_d;
      sc_addr_q    <= sc_addr_d;
      cmp_vld_q    <= cmp_vld_d;
      free_found_q <= free_found_d;
      use_rd_q     <= use_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    bn_q       <= bn_d;
    alloc_q    <= alloc_d;
    nfree_q    <= nfree_d;
    slot_q     <= slot_d;
    first_q    <= first_d;
    b_q        <= b_d;
    prev_q     <= prev_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    rsp_q      <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `FCBA_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `FCBA_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o)
  `FCBA_ASSERT_IMPL(a_err_no_block, clk_i, rst_ni,
                    done_o && rsp_o.status != fcba_pkg::ST_OK, rsp_o.result_block == '0)
  `FCBA_ASSERT_ALWAYS(a_one_port_op, clk_i, rst_ni,
                      !(dir_ctl.set_occ && dir_ctl.clr_occ))

endmodule
